@@ hw/rtl/ptps_pkg.sv @@
`timescale 1ns / 1ps
package ptps_pkg;
   localparam int Capacity = 1024;
   localparam int AddrWidth = 10;
   localparam int CountWidth = 11;
   localparam int ValueWidth = 32;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_BUILD = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NONE  = 2'd3
   } command_type;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] operand_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] predecessor_value;
      logic               found;
   } rsp_payload_type;

   // controller -> datapath
   typedef struct packed {
      logic load_write;    // append operand to sorted store
      logic build_start;   // seed range stack
      logic build_pop;     // pop range, read stack top
      logic build_emit;    // write layout node, push children
      logic build_finish;  // commit layout count, clear load count
      logic query_start;   // latch key, reset walk
      logic query_step;    // compare and descend
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic stack_empty;
      logic out_full;
      logic walk_done;
   } status_type;

   localparam CSR_SPLIT_FRACTION = 1'b0;
endpackage

@@ hw/rtl/ptps_datapath.sv @@
`timescale 1ns / 1ps
module ptps_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  ptps_pkg::ctrl_type        ctrl,
   input  logic signed [31:0]        operand_value,
   input  logic [7:0]                split_fraction,
   output ptps_pkg::status_type      status,
   output logic signed [31:0]        result_value,
   output logic                      result_found
);
   localparam int AW = ptps_pkg::AddrWidth;
   localparam int CW = ptps_pkg::CountWidth;

   logic [31:0]     sorted_mem [ptps_pkg::Capacity];
   logic [31:0]     layout_mem [ptps_pkg::Capacity];
   logic [2*CW-1:0] stack_mem  [ptps_pkg::Capacity];

   logic [CW-1:0] loaded_count_ff, loaded_count_in;
   logic [CW-1:0] layout_count_ff, layout_count_in;
   logic [CW-1:0] sp_ff, sp_in;
   logic [CW-1:0] out_ff, out_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, pivot_ff, pivot_in;
   logic [CW-1:0] idx_ff, idx_in, sz_ff, sz_in;
   logic [31:0]   key_ff, key_in;
   logic [31:0]   best_ff, best_in;
   logic          found_ff, found_in, hit_ff, hit_in;
   logic [31:0]   sorted_rd_ff;
   logic [31:0]   node_rd_ff;
   logic [2*CW-1:0] stack_rd_ff;
   logic          build_pivot_ff;

   // push addresses and data
   logic          push_right, push_left;
   logic [CW-1:0] sp_push;
   logic [CW-1:0] pop_lo, pop_hi;
   logic [CW+7:0] prod;
   logic [CW-1:0] left_sz;
   logic [31:0]   nk, kk;

   // popped range is registered and arrives in the cycle after the pop
   assign pop_lo = stack_rd_ff[2*CW-1:CW];
   assign pop_hi = stack_rd_ff[CW-1:0];

   always_comb begin
      prod = (ctrl.query_step ? sz_ff : (pop_hi - pop_lo)) * split_fraction;
      left_sz = prod[CW+7:8];
   end

   assign nk = node_rd_ff ^ 32'h8000_0000;
   assign kk = key_ff ^ 32'h8000_0000;
   assign push_right = (pivot_ff + CW'(1) < hi_ff);
   assign push_left  = (lo_ff < pivot_ff);

   always_comb begin
      loaded_count_in = loaded_count_ff;
      layout_count_in = layout_count_ff;
      sp_in = sp_ff;  out_in = out_ff;
      lo_in = lo_ff;  hi_in = hi_ff;  pivot_in = pivot_ff;
      idx_in = idx_ff; sz_in = sz_ff; key_in = key_ff;
      best_in = best_ff; found_in = found_ff; hit_in = hit_ff;
      sp_push = sp_ff;
      if (ctrl.load_write && loaded_count_ff < CW'(ptps_pkg::Capacity))
         loaded_count_in = loaded_count_ff + CW'(1);
      if (ctrl.build_start) begin
         out_in = '0;
         sp_in = (loaded_count_ff != '0) ? CW'(1) : '0;
      end
      if (ctrl.build_pop)
         sp_in = sp_ff - CW'(1);
      if (build_pivot_ff) begin
         lo_in = pop_lo;
         hi_in = pop_hi;
         pivot_in = pop_lo + left_sz;
      end
      if (ctrl.build_emit) begin
         out_in = out_ff + CW'(1);
         sp_push = sp_ff + CW'(push_right);
         sp_in = sp_push + CW'(push_left);
      end
      if (ctrl.build_finish) begin
         layout_count_in = out_ff;
         loaded_count_in = '0;
      end
      if (ctrl.query_start) begin
         key_in = operand_value; idx_in = '0; sz_in = layout_count_ff;
         best_in = '0; found_in = 1'b0; hit_in = 1'b0;
      end
      if (ctrl.query_step) begin
         if (kk == nk) begin
            best_in = node_rd_ff; found_in = 1'b1; hit_in = 1'b1;
         end else if (kk < nk) begin
            idx_in = idx_ff + CW'(1); sz_in = left_sz;
         end else begin
            best_in = node_rd_ff; found_in = 1'b1;
            idx_in = idx_ff + CW'(1) + left_sz;
            sz_in = sz_ff - left_sz - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_count_ff <= '0; layout_count_ff <= '0; sp_ff <= '0;
         out_ff <= '0; build_pivot_ff <= 1'b0;
      end else begin
         loaded_count_ff <= loaded_count_in; layout_count_ff <= layout_count_in;
         sp_ff <= sp_in; out_ff <= out_in; build_pivot_ff <= ctrl.build_pop;
      end
      lo_ff <= lo_in; hi_ff <= hi_in; pivot_ff <= pivot_in;
      idx_ff <= idx_in; sz_ff <= sz_in;
      key_ff <= key_in; best_ff <= best_in; found_ff <= found_in; hit_ff <= hit_in;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_write && loaded_count_ff < CW'(ptps_pkg::Capacity))
         sorted_mem[loaded_count_ff[AW-1:0]] <= operand_value;
      sorted_rd_ff <= sorted_mem[pivot_ff[AW-1:0]];
      if (ctrl.build_emit)
         layout_mem[out_ff[AW-1:0]] <= sorted_rd_ff;
      node_rd_ff <= layout_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ctrl.build_start)
         stack_mem[0] <= {CW'(0), loaded_count_ff};
      else if (ctrl.build_emit) begin
         if (push_right) stack_mem[sp_ff[AW-1:0]] <= {pivot_ff + CW'(1), hi_ff};
         if (push_left)  stack_mem[sp_push[AW-1:0]] <= {lo_ff, pivot_ff};
      end
      stack_rd_ff <= stack_mem[sp_ff[AW-1:0] - AW'(1)];
   end

   assign status.stack_empty = (sp_ff == '0);
   assign status.out_full = (out_ff == CW'(ptps_pkg::Capacity));
   assign status.walk_done = hit_ff || (sz_ff == '0) || !(idx_ff < layout_count_ff);
   assign result_value = found_ff ? best_ff : '0;
   assign result_found = found_ff;
endmodule

@@ hw/rtl/ptps_controller.sv @@
`timescale 1ns / 1ps
module ptps_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             command,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ptps_pkg::status_type   status,
   output ptps_pkg::ctrl_type     ctrl
);
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_BPOP   = 9'b000000010,
      ST_BPIV   = 9'b000000100,
      ST_BREAD  = 9'b000001000,
      ST_BEMIT  = 9'b000010000,
      ST_QCHK   = 9'b000100000,
      ST_QREAD  = 9'b001000000,
      ST_QSTEP  = 9'b010000000,
      ST_RESP   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (ptps_pkg::command_type'(command))
                  ptps_pkg::CMD_LOAD: ctrl.load_write = 1'b1;
                  ptps_pkg::CMD_BUILD: begin
                     ctrl.build_start = 1'b1; state_in = ST_BPOP;
                  end
                  ptps_pkg::CMD_QUERY: begin
                     ctrl.query_start = 1'b1; state_in = ST_QCHK;
                  end
                  default: ;
               endcase
            end
         end
         ST_BPOP: begin
            if (status.stack_empty || status.out_full) begin
               ctrl.build_finish = 1'b1; state_in = ST_IDLE;
            end else begin
               ctrl.build_pop = 1'b1; state_in = ST_BPIV;
            end
         end
         ST_BPIV: state_in = ST_BREAD;
         ST_BREAD: state_in = ST_BEMIT;
         ST_BEMIT: begin
            ctrl.build_emit = 1'b1; state_in = ST_BPOP;
         end
         ST_QCHK: state_in = status.walk_done ? ST_RESP : ST_QREAD;
         ST_QREAD: state_in = ST_QSTEP;
         ST_QSTEP: begin
            ctrl.query_step = 1'b1; state_in = ST_QCHK;
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

@@ hw/rtl/preorder_tree_predecessor_search.sv @@
`timescale 1ns / 1ps
// Predecessor search over a sorted set stored as a preorder search tree.
// Load beats append to the sorted store (dropped when full). A build pops
// a range off the stack memory for each node, forms the split with one
// 11x8 multiply on the registered stack read, reads the sorted store and
// writes the layout store, then commits the layout count in a closing
// step. A query walks one tree level per check, node read and
// compare/descend step, then does a final check and a response step,
// and returns one beat on rsp_. split_fraction (Q0.8, address 0)
// must only be written while idle. A new beat is taken once the previous
// result has gone out.
module preorder_tree_predecessor_search (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ptps_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ptps_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [1:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);
   ptps_pkg::ctrl_type   ctrl;
   ptps_pkg::status_type status;
   logic [7:0] split_fraction_ff;
   logic signed [31:0] res_value;
   logic res_found;

   // register file: only split_fraction at word 0
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) split_fraction_ff <= 8'd128;
      else if (csr_psel && csr_penable && csr_pwrite
               && csr_paddr[1] == ptps_pkg::CSR_SPLIT_FRACTION)
         split_fraction_ff <= csr_pwdata[7:0];
   end
   assign csr_prdata = (csr_paddr[1] == ptps_pkg::CSR_SPLIT_FRACTION)
                       ? {24'd0, split_fraction_ff} : 32'd0;

   ptps_controller u_ctrl (
      .clock, .reset, .req_valid, .req_ready,
      .command(req_payload.command), .rsp_valid, .rsp_ready,
      .status, .ctrl
   );

   ptps_datapath u_dp (
      .clock, .reset, .ctrl, .operand_value(req_payload.operand_value),
      .split_fraction(split_fraction_ff), .status,
      .result_value(res_value), .result_found(res_found)
   );

   // result registers hold stable until the query state registers change
   assign rsp_payload.predecessor_value = res_value;
   assign rsp_payload.found = res_found;
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

// Tracks the expected predecessor results and checks every rsp_ beat.
class pred_scoreboard;
   logic [31:0] sorted_mem[ptps_pkg::Capacity];
   logic [31:0] layout_mem[ptps_pkg::Capacity];
   int unsigned loaded_cnt;
   int unsigned layout_cnt;
   logic [7:0]  split_frac;
   ptps_pkg::rsp_payload_type pending_q[$];
   int errors;

   function new();
      loaded_cnt = 0;
      layout_cnt = 0;
      split_frac = 8'd128;
      errors = 0;
   endfunction

   function int unsigned left_share(int unsigned size);
      left_share = (size * split_frac) >> 8;
   endfunction

   function void build_tree();
      int unsigned lo_s[ptps_pkg::Capacity];
      int unsigned hi_s[ptps_pkg::Capacity];
      int unsigned sp, lo, hi, pivot, emitted;
      sp = 0;
      emitted = 0;
      if (loaded_cnt > 0) begin
         lo_s[0] = 0;
         hi_s[0] = loaded_cnt;
         sp = 1;
      end
      while (sp > 0 && emitted < ptps_pkg::Capacity) begin
         sp--;
         lo = lo_s[sp];
         hi = hi_s[sp];
         pivot = lo + left_share(hi - lo);
         layout_mem[emitted] = sorted_mem[pivot % ptps_pkg::Capacity];
         emitted++;
         // right range pushed first so the left one is popped first
         if (pivot + 1 < hi && sp < ptps_pkg::Capacity) begin
            lo_s[sp] = pivot + 1;
            hi_s[sp] = hi;
            sp++;
         end
         if (lo < pivot && sp < ptps_pkg::Capacity) begin
            lo_s[sp] = lo;
            hi_s[sp] = pivot;
            sp++;
         end
      end
      layout_cnt = emitted;
      loaded_cnt = 0;
   endfunction

   function void note(ptps_pkg::req_payload_type beat);
      ptps_pkg::command_type cmd;
      ptps_pkg::rsp_payload_type res;
      int unsigned idx, sz, l;
      logic [31:0] key, nk;
      cmd = ptps_pkg::command_type'(beat.command);
      case (cmd)
         ptps_pkg::CMD_LOAD: begin
            if (loaded_cnt < ptps_pkg::Capacity) begin
               sorted_mem[loaded_cnt] = beat.operand_value;
               loaded_cnt++;
            end
         end
         ptps_pkg::CMD_BUILD: build_tree();
         ptps_pkg::CMD_QUERY: begin
            res = '0;
            idx = 0;
            sz = layout_cnt;
            // flip sign bit so unsigned compare orders signed values
            key = beat.operand_value ^ 32'h8000_0000;
            while (sz > 0 && idx < layout_cnt) begin
               nk = layout_mem[idx] ^ 32'h8000_0000;
               l = left_share(sz);
               if (key == nk) begin
                  res.predecessor_value = layout_mem[idx];
                  res.found = 1'b1;
                  break;
               end
               if (key < nk) begin
                  idx += 1;
                  sz = l;
               end else begin
                  res.predecessor_value = layout_mem[idx];
                  res.found = 1'b1;
                  idx += 1 + l;
                  sz = sz - l - 1;
               end
            end
            pending_q = {pending_q, res};
         end
         default: ;
      endcase
   endfunction

   function void check(ptps_pkg::rsp_payload_type got);
      ptps_pkg::rsp_payload_type exp;
      if (pending_q.size() == 0) begin
         $error("unexpected rsp beat: value %0d found %0b",
                got.predecessor_value, got.found);
         errors++;
         return;
      end
      exp = pending_q.pop_front();
      if (got.predecessor_value !== exp.predecessor_value) begin
         $error("predecessor_value: expected %0d, got %0d",
                exp.predecessor_value, got.predecessor_value);
         errors++;
      end
      if (got.found !== exp.found) begin
         $error("found: expected %0b, got %0b", exp.found, got.found);
         errors++;
      end
   endfunction
endclass

module tb_top;
   localparam int BuildWait = 4300;  // long enough for the worst build, with a full store

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   ptps_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ptps_pkg::rsp_payload_type rsp_payload;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   pred_scoreboard sb;
   bit calm = 1'b0;        // no idling on either side while set
   int beats_sent = 0;

   preorder_tree_predecessor_search DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Monitor: values seen here are the ones present before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note(req_payload);
         if (rsp_valid && rsp_ready) sb.check(rsp_payload);
      end
   end

   // Result-side backpressure, ~9% stall.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= calm || ($urandom_range(0, 99) >= 9);
   end

   task automatic send(ptps_pkg::command_type cmd, logic [31:0] value);
      if (!calm && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload.command <= cmd;
      req_payload.operand_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      calm = (beats_sent >= 250 && beats_sent < 400);
   endtask

   // Quiet the input side and let pending results and any build finish.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (BuildWait) @(posedge clock);
   endtask

   task automatic csr_write(logic [7:0] frac);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {ptps_pkg::CSR_SPLIT_FRACTION, 1'b0};
      csr_pwdata <= {24'd0, frac};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.split_frac = frac;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic rand_value(output logic [31:0] v, input bit narrow);
      case ($urandom_range(0, 9))
         0: v = 32'h8000_0000;
         1: v = 32'h7fff_ffff;
         default: v = narrow ? 32'($signed($urandom_range(0, 200)) - 100) : $urandom;
      endcase
   endtask

   // One load/build/query set with random content.
   task automatic random_set(int n, int queries);
      logic [31:0] vals[$];
      logic [31:0] v;
      int signed sv[$];
      bit narrow, unsorted;
      narrow = $urandom_range(0, 1);
      unsorted = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < n; i++) begin
         rand_value(v, narrow);
         sv = {sv, int'(v)};
      end
      if (!unsorted) sv.sort();
      foreach (sv[i]) begin
         send(ptps_pkg::CMD_LOAD, sv[i]);
         vals = {vals, 32'(sv[i])};
      end
      if ($urandom_range(0, 19) == 0) send(ptps_pkg::CMD_NONE, $urandom);
      send(ptps_pkg::CMD_BUILD, $urandom);
      for (int q = 0; q < queries; q++) begin
         if (vals.size() > 0 && $urandom_range(0, 2) != 0) begin
            v = vals[$urandom_range(0, vals.size() - 1)];
            v = v + 32'($signed($urandom_range(0, 2)) - 1);
         end else begin
            rand_value(v, narrow);
         end
         send(ptps_pkg::CMD_QUERY, v);
      end
   endtask

   initial begin
      logic [7:0] fracs[6];
      int n;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty tree, empty build, unused command
      send(ptps_pkg::CMD_QUERY, 32'd5);
      send(ptps_pkg::CMD_BUILD, 32'd0);
      send(ptps_pkg::CMD_QUERY, 32'h8000_0000);
      send(ptps_pkg::CMD_NONE, 32'hffff_ffff);
      // extremes, exact matches at both ends
      send(ptps_pkg::CMD_LOAD, 32'h8000_0000);
      send(ptps_pkg::CMD_LOAD, -32'sd5);
      send(ptps_pkg::CMD_LOAD, 32'd0);
      send(ptps_pkg::CMD_LOAD, 32'd7);
      send(ptps_pkg::CMD_LOAD, 32'h7fff_ffff);
      send(ptps_pkg::CMD_BUILD, 32'hffff_ffff);
      send(ptps_pkg::CMD_QUERY, 32'h8000_0000);
      send(ptps_pkg::CMD_QUERY, 32'h7fff_ffff);
      send(ptps_pkg::CMD_QUERY, 32'd6);
      send(ptps_pkg::CMD_QUERY, -32'sd1);
      // key below every stored value, then unsorted loads
      send(ptps_pkg::CMD_LOAD, 32'd10);
      send(ptps_pkg::CMD_LOAD, 32'd20);
      send(ptps_pkg::CMD_LOAD, 32'd30);
      send(ptps_pkg::CMD_BUILD, 32'd0);
      send(ptps_pkg::CMD_QUERY, 32'd5);
      send(ptps_pkg::CMD_QUERY, 32'd20);
      send(ptps_pkg::CMD_QUERY, 32'd25);
      send(ptps_pkg::CMD_LOAD, 32'd50);
      send(ptps_pkg::CMD_LOAD, -32'sd3);
      send(ptps_pkg::CMD_LOAD, 32'd9);
      send(ptps_pkg::CMD_BUILD, 32'd0);
      send(ptps_pkg::CMD_QUERY, 32'd9);
      send(ptps_pkg::CMD_QUERY, 32'd60);

      fracs[0] = 8'd1;
      fracs[1] = 8'd255;
      fracs[2] = 8'($urandom_range(2, 254));
      fracs[3] = 8'd128;
      fracs[4] = 8'($urandom_range(2, 254));
      fracs[5] = 8'd64;
      foreach (fracs[p]) begin
         settle();
         csr_write(fracs[p]);
         for (int k = 0; k < 75;) begin
            n = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 200)
                                              : $urandom_range(0, 12);
            random_set(n, $urandom_range(3, 10));
            k += n + 8;
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end
endmodule
